FILE: design/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, codes and constants for the ADC sample correction and capture
// core.
// ----------------------------------------------------------------------------
package asc_pkg;

   // buffer geometry
   localparam int BUFFER_SAMPLES = 1024;
   localparam int IDX_W          = $clog2(BUFFER_SAMPLES);
   localparam int HALF_SAMPLES   = BUFFER_SAMPLES / 2;

   // field widths
   localparam int RAW_W    = 11;
   localparam int NUM_RAW  = 8;
   localparam int SAMPLE_W = 14;
   localparam int ADDR_W   = 10;
   localparam int KIND_W   = 2;
   localparam int NOTE_W   = 2;

   // correction constants
   localparam logic [7:0] CORR_OFFSET = 8'd21;
   localparam logic [8:0] CORR_GAIN   = 9'd279;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 14'd16376;

   // transaction kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_STOP  = 2'd2
   } kind_type;

   // notify codes
   localparam logic [NOTE_W-1:0] NOTE_NONE   = 2'd0;
   localparam logic [NOTE_W-1:0] NOTE_FIRST  = 2'd1;
   localparam logic [NOTE_W-1:0] NOTE_SECOND = 2'd2;

   // capture control result for one transaction
   typedef struct packed {
      logic                emit;
      logic [ADDR_W-1:0]   addr;
      logic [NOTE_W-1:0]   notify;
   } ctrl_type;

endpackage

FILE: design/asc_correct.sv
// ----------------------------------------------------------------------------
// asc_correct
// Corrects one raw ADC word: invert, keep the high bits, and add the scaled
// low byte above the offset.
// ----------------------------------------------------------------------------
module asc_correct
   import asc_pkg::*;
(
   input  logic [RAW_W-1:0] raw,
   output logic [RAW_W-1:0] corr
);

   logic [RAW_W-1:0] inv;
   logic [7:0]       low;
   logic [7:0]       above;
   logic [16:0]      prod;

   // inversion and split into high bits and low byte
   assign inv   = ~raw;
   assign low   = inv[7:0];
   assign above = low - CORR_OFFSET;
   assign prod  = {9'd0, above} * {8'd0, CORR_GAIN};

   // low byte adds on only when above the offset
   always_comb begin
      corr = {inv[RAW_W-1:8], 8'h00};
      if (low > CORR_OFFSET) begin
         corr = {inv[RAW_W-1:8], 8'h00} + {3'b000, prod[15:8]};
      end
   end

endmodule

FILE: design/asc_capture_ctrl.sv
// ----------------------------------------------------------------------------
// asc_capture_ctrl
// Capture state: running flag, skip of the first tick after start and the
// ping-pong buffer fill index with half and full notify.
// ----------------------------------------------------------------------------
module asc_capture_ctrl
   import asc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [KIND_W-1:0] kind,
   output ctrl_type          ctl
);

   logic             running_ff, running_in;
   logic             skip_ff, skip_in;
   logic [IDX_W-1:0] fill_index_ff, fill_index_in;
   logic [IDX_W:0]   idx_next;

   assign idx_next = {1'b0, fill_index_ff} + (IDX_W+1)'(1);

   // next state and result for the transaction at the head of the stage
   always_comb begin
      running_in    = running_ff;
      skip_in       = skip_ff;
      fill_index_in = fill_index_ff;
      ctl.emit      = 1'b0;
      ctl.addr      = ADDR_W'(fill_index_ff);
      ctl.notify    = NOTE_NONE;
      unique case (kind)
         KIND_START: begin
            running_in    = 1'b1;
            skip_in       = 1'b1;
            fill_index_in = '0;
         end
         KIND_STOP: begin
            running_in = 1'b0;
         end
         KIND_TICK: begin
            if (running_ff && skip_ff) begin
               skip_in       = 1'b0;
               fill_index_in = '0;
            end else if (running_ff) begin
               ctl.emit = 1'b1;
               if (idx_next == (IDX_W+1)'(HALF_SAMPLES)) begin
                  ctl.notify = NOTE_FIRST;
               end else if (idx_next == (IDX_W+1)'(BUFFER_SAMPLES)) begin
                  ctl.notify = NOTE_SECOND;
               end
               if (idx_next >= (IDX_W+1)'(BUFFER_SAMPLES)) begin
                  fill_index_in = '0;
               end else begin
                  fill_index_in = idx_next[IDX_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      if (!go) begin
         ctl.emit = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         skip_ff       <= 1'b0;
         fill_index_ff <= '0;
      end else if (go) begin
         running_ff    <= running_in;
         skip_ff       <= skip_in;
         fill_index_ff <= fill_index_in;
      end
   end

`ifndef SYNTH
   // index stays inside the buffer
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, fill_index_ff} < (IDX_W+1)'(BUFFER_SAMPLES))
      else $error("fill index out of range");

   // a processed start arms the skip and clears the index
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (go && kind == KIND_START) |=> (skip_ff && running_ff && fill_index_ff == '0))
      else $error("start did not arm capture");

   // nothing is emitted while stopped or skipping
   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (!running_ff || skip_ff) |-> !ctl.emit)
      else $error("emit while stopped or skipping");
`endif

endmodule

FILE: design/adc_sample_correct_capture_core.sv
// ----------------------------------------------------------------------------
// adc_sample_correct_capture_core
// ADC sample correction and ping-pong buffer capture: corrects and sums eight
// raw ADC words per tick and tags each sample with its buffer address.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  req_*     in         kind in tuser, eight raw ADC words in tdata
//  rsp_*     out        sample value and write address in tdata, notify in tuser
//
//  one transaction per cycle while results are taken: input register, correction and sum, result register
//  an accepted transaction is held in the input register and its result in the result register
//  ticks while stopped, the first tick after start, starts and stops give no result
//  reset clears capture state and both valid flags; capture starts stopped
//  a stalled result holds the input register, which then holds req_tready low
// ----------------------------------------------------------------------------
module adc_sample_correct_capture_core
   import asc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // raw_0 .. raw_7, 11 bits each
   input  logic [1:0]   req_tuser,   // kind
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // sample_value[13:0], write_address[23:14]
   output logic [1:0]   rsp_tuser    // notify
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]      s1_kind_ff;
   logic [RAW_W-1:0]       s1_raw_ff [NUM_RAW];
   logic                   s1_go;
   logic [RAW_W-1:0]       corr [NUM_RAW];
   logic [SAMPLE_W-1:0]    sum;
   ctrl_type               ctl;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_sample_ff;
   logic [ADDR_W-1:0]      rsp_addr_ff;
   logic [NOTE_W-1:0]      rsp_note_ff;

   // stage handshake
   assign s1_go       = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_go);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_kind_ff <= req_tuser;
         for (int i = 0; i < NUM_RAW; i++) begin
            s1_raw_ff[i] <= req_tdata[i*RAW_W +: RAW_W];
         end
      end
   end

   // per-word correction
   for (genvar g = 0; g < NUM_RAW; g++) begin : g_corr
      asc_correct u_correct (
         .raw  (s1_raw_ff[g]),
         .corr (corr[g])
      );
   end

   // sum of corrected words
   always_comb begin
      sum = '0;
      for (int i = 0; i < NUM_RAW; i++) begin
         sum = sum + SAMPLE_W'(corr[i]);
      end
   end

   // capture control
   asc_capture_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .go    (s1_go),
      .kind  (s1_kind_ff),
      .ctl   (ctl)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_go) begin
         rsp_valid_in = ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && ctl.emit) begin
         rsp_sample_ff <= sum;
         rsp_addr_ff   <= ctl.addr;
         rsp_note_ff   <= ctl.notify;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_addr_ff, rsp_sample_ff};
   assign rsp_tuser  = rsp_note_ff;

`ifndef SYNTH
   // notify code is one of the defined ones
   a_note_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_note_ff == NOTE_NONE || rsp_note_ff == NOTE_FIRST ||
                        rsp_note_ff == NOTE_SECOND))
      else $error("illegal notify code");

   // first-half notify sits on the last address of the first half
   a_half_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_note_ff == NOTE_FIRST) |->
         rsp_addr_ff == ADDR_W'(HALF_SAMPLES - 1))
      else $error("first-half notify at wrong address");

   // sample never exceeds the eight-word maximum
   a_sample_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sample_ff <= SAMPLE_MAX)
      else $error("sample value out of range");
`endif

endmodule
